/* design/bad_pkg.sv */
// bad_pkg: shared types and constants of the bounded array deque
`timescale 1ns / 1ps

package bad_pkg;

   localparam int VALUE_W = 32;
   localparam int CAP_W   = 5;

   localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
   localparam logic [VALUE_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_REAR  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_REAR   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   // what the pointer unit hands to the read stage for one transaction
   typedef struct packed {
      logic       pop_ok;
      status_type status;
   } issue_type;

endpackage

/* design/bad_slot_mem.sv */
// bad_slot_mem: single-port slot memory with a registered read
`timescale 1ns / 1ps

module bad_slot_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 addr,
   input  logic [bad_pkg::VALUE_W-1:0]   wdata,
   output logic [bad_pkg::VALUE_W-1:0]   rdata_ff
);
   import bad_pkg::*;

   logic [VALUE_W-1:0] slot_mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= slot_mem_ff[addr];
      end
   end

endmodule

/* design/bad_ptr_ctrl.sv */
// bad_ptr_ctrl: head and tail pointers, capacity register and command decode
`timescale 1ns / 1ps

module bad_ptr_ctrl #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [1:0]                 command,
   input  logic                       csr_wr,
   input  logic [bad_pkg::CAP_W-1:0]  csr_wdata,
   output logic                       mem_wr_en,
   output logic                       mem_rd_en,
   output logic [AW-1:0]              mem_addr,
   output bad_pkg::issue_type         issue
);
   import bad_pkg::*;

   localparam int PW = $clog2(DEPTH + 1);
   localparam int CW = (PW > CAP_W) ? PW : CAP_W;
   localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);

   logic [PW-1:0]    head_ff, head_in;
   logic [PW-1:0]    tail_ff, tail_in;
   logic [CAP_W-1:0] cap_ff;

   logic [CW-1:0] cap_ext, eff_cap, tail_ext;
   logic [PW-1:0] head_m1, tail_m1;
   logic          empty;
   logic          do_wr, do_rd;
   logic [PW-1:0] ptr_sel;
   cmd_type       cmd;

   assign cmd      = cmd_type'(command);
   assign cap_ext  = CW'(cap_ff);
   assign eff_cap  = (cap_ext > DEPTH_CW) ? DEPTH_CW : cap_ext;
   assign tail_ext = CW'(tail_ff);
   assign head_m1  = head_ff - PW'(1);
   assign tail_m1  = tail_ff - PW'(1);
   assign empty    = (head_ff == tail_ff);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      do_wr         = 1'b0;
      do_rd         = 1'b0;
      ptr_sel       = head_ff;
      issue.pop_ok  = 1'b0;
      issue.status  = ST_OK;
      case (cmd)
         CMD_PUSH_FRONT: begin
            if (head_ff == '0) begin
               issue.status = ST_OVERFLOW;
            end else begin
               do_wr   = 1'b1;
               ptr_sel = head_m1;
               head_in = head_m1;
            end
         end
         CMD_PUSH_REAR: begin
            if (tail_ext >= eff_cap) begin
               issue.status = ST_OVERFLOW;
            end else begin
               do_wr   = 1'b1;
               ptr_sel = tail_ff;
               tail_in = tail_ff + PW'(1);
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               issue.status = ST_UNDERFLOW;
            end else begin
               do_rd        = 1'b1;
               issue.pop_ok = 1'b1;
               ptr_sel      = head_ff;
               head_in      = head_ff + PW'(1);
            end
         end
         default: begin
            if (empty) begin
               issue.status = ST_UNDERFLOW;
            end else begin
               do_rd        = 1'b1;
               issue.pop_ok = 1'b1;
               ptr_sel      = tail_m1;
               tail_in      = tail_m1;
            end
         end
      endcase
   end

   // every live slot index stays below DEPTH, so the low bits address the memory
   assign mem_addr  = ptr_sel[AW-1:0];
   assign mem_wr_en = accept && do_wr;
   assign mem_rd_en = accept && do_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cap_ff  <= CAP_RESET;
      end else begin
         if (accept) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
         end
         if (csr_wr) begin
            cap_ff <= csr_wdata;
         end
      end
   end

endmodule

/* design/bounded_array_deque.sv */
// bounded_array_deque: top level of the linear-array deque with registered result
`timescale 1ns / 1ps

// Deque held in a linear, non-circular array of DEPTH 32-bit slots in one
// single-port memory with a registered read. Each request
// transaction carries a command (push front, push rear, pop front, pop rear)
// and a value, and yields exactly one response transaction of value and
// status (ok, overflow, underflow). Pops on an empty deque and all pushes
// return minus one. Front pushes only reuse slots freed by earlier front
// pops; a front push with the head at slot zero overflows. Rear pushes
// overflow once the tail reaches the capacity register (values above DEPTH
// act as DEPTH, zero blocks all rear pushes). Pointers are not rewound when
// the deque empties. Rate: one request per cycle while the output register
// keeps draining. A taken request passes the memory access and pointer
// update, then the read-data stage into the output register. Request ready
// drops only while the read stage holds a result and the output register is
// full and not being taken. The capacity register is written through the
// csr channel, always ready; the user writes it only while idle (not enforced).

module bounded_array_deque #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_command,
   input  logic signed [bad_pkg::VALUE_W-1:0] req_value_in,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [bad_pkg::VALUE_W-1:0] rsp_value_out,
   output logic [1:0]                        rsp_status,
   // capacity register write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bad_pkg::CAP_W-1:0]         csr_wdata
);
   import bad_pkg::*;

   localparam int AW = $clog2(DEPTH);

   // handshake
   logic accept;
   logic out_free;

   // memory access issued at accept
   logic               mem_wr_en;
   logic               mem_rd_en;
   logic [AW-1:0]      mem_addr;
   logic [VALUE_W-1:0] mem_rdata_ff;
   issue_type          issue;

   // read-data stage
   logic      pend_ff, pend_in;
   issue_type pend_info_ff;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff;
   status_type         rsp_status_ff;
   logic               load_out;

   assign csr_ready = 1'b1;

   // output register frees when empty or taken this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_out  = pend_ff && out_free;
   assign req_ready = !pend_ff || out_free;
   assign accept    = req_valid && req_ready;

   bad_ptr_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ptr_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (req_command),
      .csr_wr    (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .mem_wr_en (mem_wr_en),
      .mem_rd_en (mem_rd_en),
      .mem_addr  (mem_addr),
      .issue     (issue)
   );

   // a write lands at the accept edge, so the next transaction's read already
   // sees it: no forwarding needed with one access per cycle
   bad_slot_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_slot_mem (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .rd_en    (mem_rd_en),
      .addr     (mem_addr),
      .wdata    (req_value_in),
      .rdata_ff (mem_rdata_ff)
   );

   // read stage holds its result until the output register takes it
   assign pend_in      = accept || (pend_ff && !out_free);
   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_info_ff <= issue;
      end
      if (load_out) begin
         rsp_value_ff  <= pend_info_ff.pop_ok ? mem_rdata_ff : MINUS_ONE;
         rsp_status_ff <= pend_info_ff.status;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

   // every taken request reaches the read stage
   a_accept_to_pend : assert property (@(posedge clock) disable iff (reset)
      accept |=> pend_ff)
      else $error("accepted transaction lost before read stage");

   // a read-stage result moves into a free output register
   a_pend_to_out : assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_valid_ff)
      else $error("read-stage result not moved to output");

   // only a successful pop reads the memory
   a_pop_ok_status : assert property (@(posedge clock) disable iff (reset)
      pend_ff && pend_info_ff.pop_ok |-> pend_info_ff.status == ST_OK)
      else $error("memory read flagged for a failed command");

   // failed commands always answer minus one
   a_fail_value : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_value_ff == MINUS_ONE)
      else $error("failed command returned a value other than minus one");

endmodule

/* verif/tb_bounded_array_deque.sv */
// tb_bounded_array_deque: self-checking testbench of the bounded array deque
`timescale 1ns / 1ps

// The stimulus process fills a queue of pending request transactions. A clocked
// driver feeds the request channel from it, and each accepted transaction
// advances a local copy of the deque (slots, head, tail, capacity) that
// computes the expected response. A clocked monitor takes each response
// transaction and compares it field by field with the oldest expected one.
// Both sides idle in random bursts, and the response side holds off once for
// a long stretch so that the block fills up and stalls its input. Each
// capacity setting is written only while the block is idle.

module tb_bounded_array_deque;
   import bad_pkg::*;

   localparam int SLOT_COUNT   = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 93;
   localparam int SETTLE_WAIT  = 4;      // settle margin after the last response
   localparam int HOLD_AT_RSP  = 60;     // long hold starts after this many responses
   localparam int HOLD_CYCLES  = 80;

   typedef struct {
      cmd_type              command;
      logic [VALUE_W-1:0]   value;
   } deque_request_type;

   typedef struct {
      logic [VALUE_W-1:0]   value;
      status_type           status;
   } deque_result_type;

   // clock, reset and block inputs, all known from time zero
   logic                       clock        = 1'b0;
   logic                       reset        = 1'b1;
   logic                       req_valid    = 1'b0;
   logic [1:0]                 req_command  = CMD_PUSH_REAR;
   logic signed [VALUE_W-1:0]  req_value_in = '0;
   logic                       rsp_ready    = 1'b0;
   logic                       csr_valid    = 1'b0;
   logic [CAP_W-1:0]           csr_wdata    = '0;

   logic                       req_ready;
   logic                       rsp_valid;
   logic signed [VALUE_W-1:0]  rsp_value_out;
   logic [1:0]                 rsp_status;
   logic                       csr_ready;

   // request transactions waiting to be driven, responses waiting to arrive
   deque_request_type pending_requests[$];
   deque_result_type  expected_results[$];

   // local copy of the deque
   logic [VALUE_W-1:0] model_slots[SLOT_COUNT];
   logic [CAP_W-1:0]   model_head     = '0;
   logic [CAP_W-1:0]   model_tail     = '0;
   logic [CAP_W-1:0]   model_capacity = CAP_RESET;

   int   error_count = 0;
   int   cycle_count = 0;
   int   rsp_count   = 0;
   int   send_gap    = 0;
   int   stall_left  = 0;
   int   hold_left   = 0;
   bit   hold_done   = 1'b0;
   bit   steady_run  = 1'b0;   // no idling in the last part of the run

   bounded_array_deque #(
      .DEPTH(SLOT_COUNT)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // one printed line per mismatch
   task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                  logic [VALUE_W-1:0] want);
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
      error_count++;
   endtask

   // applies one command to the local deque and returns its response
   function automatic deque_result_type apply_deque_command(cmd_type command,
                                                            logic [VALUE_W-1:0] value);
      deque_result_type result;
      logic [CAP_W-1:0] rear_limit;
      logic             is_empty;
      result.value  = MINUS_ONE;
      result.status = ST_OK;
      // capacity above the slot count acts as the slot count, zero blocks rear pushes
      rear_limit = (model_capacity > SLOT_COUNT) ? CAP_W'(SLOT_COUNT) : model_capacity;
      is_empty   = (model_head == model_tail);
      case (command)
         CMD_PUSH_FRONT: begin
            // front pushes only refill slots freed by front pops
            if (model_head == 0) begin
               result.status = ST_OVERFLOW;
            end else begin
               model_head = model_head - 1'b1;
               model_slots[model_head[3:0]] = value;
            end
         end
         CMD_PUSH_REAR: begin
            if (model_tail >= rear_limit) begin
               result.status = ST_OVERFLOW;
            end else begin
               model_slots[model_tail[3:0]] = value;
               model_tail = model_tail + 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (is_empty) begin
               result.status = ST_UNDERFLOW;
            end else begin
               result.value = model_slots[model_head[3:0]];
               model_head = model_head + 1'b1;
            end
         end
         default: begin
            if (is_empty) begin
               result.status = ST_UNDERFLOW;
            end else begin
               model_tail = model_tail - 1'b1;
               result.value = model_slots[model_tail[3:0]];
            end
         end
      endcase
      return result;
   endfunction

   // driver: predicts on each accepted transaction, then presents the next one
   always @(posedge clock) begin
      deque_request_type next_request;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(apply_deque_command(cmd_type'(req_command),
                                                           req_value_in));
         end
         // payload may change only when nothing is offered or it was just taken
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!steady_run && $urandom_range(0, 11) == 0) begin
               send_gap = $urandom_range(0, 14);
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               next_request = pending_requests.pop_front();
               req_valid    <= 1'b1;
               req_command  <= next_request.command;
               req_value_in <= next_request.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each response transaction and drives the response ready
   always @(posedge clock) begin
      deque_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("response with nothing expected", rsp_value_out, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_value_out !== want.value)
                  report_mismatch("value_out", rsp_value_out, want.value);
               if (rsp_status !== want.status)
                  report_mismatch("status", VALUE_W'(rsp_status), VALUE_W'(want.status));
            end
         end
         // one long hold so the block backs up into its input
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && rsp_count >= HOLD_AT_RSP) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!steady_run && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic queue_request(cmd_type command, logic [VALUE_W-1:0] value);
      deque_request_type item;
      item.command = command;
      item.value   = value;
      pending_requests.push_back(item);
   endtask

   // random data half the time, the extremes otherwise
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // runs of fills and drains at either end, mixed with random commands
   task automatic queue_random_requests(int count);
      int      made;
      int      run;
      int      shape;
      cmd_type command;
      made = 0;
      while (made < count) begin
         shape = $urandom_range(0, 9);
         run   = $urandom_range(1, 8);
         for (int k = 0; k < run && made < count; k++) begin
            case (shape)
               0, 1, 2: command = CMD_PUSH_REAR;
               3:       command = CMD_PUSH_FRONT;
               4, 5:    command = CMD_POP_FRONT;
               6:       command = CMD_POP_REAR;
               default: command = cmd_type'($urandom_range(0, 3));
            endcase
            queue_request(command, pick_value());
            made++;
         end
      end
   endtask

   // capacity write through the csr channel
   task automatic write_capacity(logic [CAP_W-1:0] capacity);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= capacity;
      do @(posedge clock); while (!csr_ready);
      model_capacity = capacity;
      csr_valid <= 1'b0;
   endtask

   // block idle: nothing queued, nothing offered, nothing outstanding
   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   initial begin
      logic [CAP_W-1:0] capacity_plan[$];
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: underflow at both ends and front push at slot zero
      queue_request(CMD_POP_FRONT, $urandom);
      queue_request(CMD_POP_REAR, $urandom);
      queue_request(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
      // extreme values in, then out from the front
      queue_request(CMD_PUSH_REAR, 32'h8000_0000);
      queue_request(CMD_PUSH_REAR, 32'h7FFF_FFFF);
      queue_request(CMD_PUSH_REAR, 32'h0000_0000);
      queue_request(CMD_PUSH_REAR, 32'hFFFF_FFFF);
      queue_request(CMD_PUSH_REAR, 32'h5555_5555);
      queue_request(CMD_PUSH_REAR, 32'hAAAA_AAAA);
      queue_request(CMD_POP_FRONT, $urandom);
      queue_request(CMD_POP_FRONT, $urandom);
      // front push lands in the slot just freed
      queue_request(CMD_PUSH_FRONT, 32'h1234_5678);
      queue_request(CMD_POP_REAR, $urandom);
      // fill to the reset capacity, then one rear push past it
      for (int k = 0; k < 12; k++)
         queue_request(CMD_PUSH_REAR, pick_value());
      queue_request(CMD_POP_REAR, $urandom);
      wait_until_drained();

      // capacity settings: one, zero, all ones, just past the slot count, five, random
      capacity_plan = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'($urandom_range(0, 31))};
      foreach (capacity_plan[p]) begin
         write_capacity(capacity_plan[p]);
         queue_random_requests(PHASE_ITEMS);
         wait_until_drained();
      end

      // last part at full capacity with both sides always ready
      steady_run = 1'b1;
      write_capacity(CAP_W'(SLOT_COUNT));
      queue_random_requests(PHASE_ITEMS);
      wait_until_drained();

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
